@@ hw/rtl/wsp_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wsp_pkg - shared types and constants for the wall sensor peak classifier
// Item action codes, register indexes, reset thresholds and the records that
// pass between the peak bank, the classifier and the top level.
// ============================================================================
package wsp_pkg;

    // Default converter width
    localparam int SAMPLE_BITS_DEF = 12;

    // Number of sensor channels and the width of a channel number
    localparam int NUM_CHANNELS = 4;
    localparam int CHAN_BITS    = 2;

    // Item action codes
    localparam logic [1:0] ACT_SAMPLE   = 2'd0;
    localparam logic [1:0] ACT_CLASSIFY = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE_A      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE_B      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRONT_LEFT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRONT_RIGHT = 2'd3;

    // Threshold reset levels
    localparam int SIDE_A_RST      = 2330;
    localparam int SIDE_B_RST      = 2335;
    localparam int FRONT_LEFT_RST  = 2310;
    localparam int FRONT_RIGHT_RST = 2650;

    // Upper nibble of every wall report
    localparam logic [7:0] WALL_FILL = 8'hF0;

    // Wall positions in the heading-relative nibble
    localparam logic [3:0] NIB_SIDE_A = 4'h8;
    localparam logic [3:0] NIB_FRONT  = 4'h1;
    localparam logic [3:0] NIB_SIDE_B = 4'h2;

    // Command to the peak bank for one item
    typedef struct packed {
        logic                 sample_en;
        logic                 clear;
        logic [CHAN_BITS-1:0] channel;
    } t_peak_cmd;

    // One classify result
    typedef struct packed {
        logic [7:0] wall_bits;
        logic       side_a;
        logic       front;
        logic       side_b;
    } t_class_res;

endpackage

@@ hw/rtl/wsp_peak_bank.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wsp_peak_bank - peak-hold registers for the four sensor channels
// Raise the addressed peak when a sample reaches or exceeds it; clear all
// peaks on command.
// ============================================================================
module wsp_peak_bank import wsp_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_peak_cmd              i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_peaks [NUM_CHANNELS]
);

    logic [SAMPLE_BITS-1:0] r_peaks [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] n_peaks [NUM_CHANNELS];

    always_comb begin
        n_peaks = r_peaks;
        if (i_cmd.clear) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                n_peaks[k] = '0;
            end
        end else if (i_cmd.sample_en && (i_sample >= r_peaks[i_cmd.channel])) begin
            n_peaks[i_cmd.channel] = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_peaks[k] <= '0;
            end
        end else begin
            r_peaks <= n_peaks;
        end
    end

    assign o_peaks = r_peaks;

endmodule

@@ hw/rtl/wsp_classify.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wsp_classify - wall decision and heading rotation
// Compare the peaks with the thresholds and rotate the wall nibble by the
// position of the lowest set heading bit, modulo four.
// ============================================================================
module wsp_classify import wsp_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0] i_peaks [NUM_CHANNELS],
    input  logic [SAMPLE_BITS-1:0] i_thr_side_a,
    input  logic [SAMPLE_BITS-1:0] i_thr_side_b,
    input  logic [SAMPLE_BITS-1:0] i_thr_front_left,
    input  logic [SAMPLE_BITS-1:0] i_thr_front_right,
    input  logic [7:0]             i_heading,
    output t_class_res             o_res
);

    function automatic logic [3:0] rotl_nibble(input logic [3:0] v, input logic [1:0] r);
        logic [7:0] dbl;
        dbl = {v, v} << r;
        return dbl[7:4];
    endfunction

    logic [1:0] rot;
    logic       side_a;
    logic       front;
    logic       side_b;
    logic [3:0] nib;

    // Lowest set bit wins; an empty heading leaves the nibble unrotated
    always_comb begin
        rot = 2'd0;
        for (int b = 7; b >= 0; b--) begin
            if (i_heading[b]) begin
                rot = b[1:0];
            end
        end
    end

    always_comb begin
        side_a = i_peaks[0] >= i_thr_side_a;
        side_b = i_peaks[1] >= i_thr_side_b;
        front  = (i_peaks[2] >= i_thr_front_left) && (i_peaks[3] >= i_thr_front_right);
        nib    = '0;
        if (side_a) nib = nib | rotl_nibble(NIB_SIDE_A, rot);
        if (front)  nib = nib | rotl_nibble(NIB_FRONT, rot);
        if (side_b) nib = nib | rotl_nibble(NIB_SIDE_B, rot);
        o_res.wall_bits = WALL_FILL | {4'h0, nib};
        o_res.side_a    = side_a;
        o_res.front     = front;
        o_res.side_b    = side_b;
    end

endmodule

@@ hw/rtl/wall_sensor_peak_classifier.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wall_sensor_peak_classifier - peak hold and wall classification
// Four channel peak-hold with threshold-based wall detection, rotated into
// absolute directions by the robot heading.
// ============================================================================
// The block takes one item per clock while o_stall is low. Each accepted
// item lands in an input register, where it is worked on: a sample item
// raises the addressed channel's peak if the reading is greater or equal, a
// clear item zeroes all four peaks, and a classify item compares the held
// peaks with the four thresholds and produces one result item in the output
// register, from which the result is presented on o_valid. Sample, clear and
// the unused action code produce no result. Throughput is one item per cycle;
// the only thing that holds the input back is a classify item waiting in the
// input register while the output register is full and stalled. Thresholds
// are written through the configuration port (always ready); the user must
// write them only while the block is idle, which the block itself does not
// enforce. A write takes effect on the next item.
// ============================================================================
module wall_sensor_peak_classifier import wsp_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Item input channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_action,
    input  logic [CHAN_BITS-1:0]    i_channel,
    input  logic [SAMPLE_BITS-1:0]  i_sample,
    input  logic [7:0]              i_heading,
    // Result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [7:0]              o_wall_bits,
    output logic                    o_side_a_lamp,
    output logic                    o_front_lamp,
    output logic                    o_side_b_lamp,
    // Configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // Threshold registers
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] r_thr_side_a;
    logic [SAMPLE_BITS-1:0] r_thr_side_b;
    logic [SAMPLE_BITS-1:0] r_thr_front_left;
    logic [SAMPLE_BITS-1:0] r_thr_front_right;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_side_a      <= SAMPLE_BITS'(SIDE_A_RST);
            r_thr_side_b      <= SAMPLE_BITS'(SIDE_B_RST);
            r_thr_front_left  <= SAMPLE_BITS'(FRONT_LEFT_RST);
            r_thr_front_right <= SAMPLE_BITS'(FRONT_RIGHT_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SIDE_A:      r_thr_side_a      <= i_cfg_data;
                CFG_SIDE_B:      r_thr_side_b      <= i_cfg_data;
                CFG_FRONT_LEFT:  r_thr_front_left  <= i_cfg_data;
                CFG_FRONT_RIGHT: r_thr_front_right <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                   r_in_valid;
    logic [1:0]             r_in_action;
    logic [CHAN_BITS-1:0]   r_in_channel;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic [7:0]             r_in_heading;

    logic in_accept;
    logic in_is_class;
    logic in_consume;

    // A classify item needs a free (or draining) output register;
    // every other action retires unconditionally.
    assign in_is_class = r_in_action == ACT_CLASSIFY;
    assign in_consume  = r_in_valid && (!in_is_class || !o_valid || !i_stall);
    assign o_stall     = r_in_valid && !in_consume;
    assign in_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (in_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_action  <= i_action;
            r_in_channel <= i_channel;
            r_in_sample  <= i_sample;
            r_in_heading <= i_heading;
        end
    end

    // ------------------------------------------------------------------
    // Peak bank and classifier
    // ------------------------------------------------------------------
    t_peak_cmd              peak_cmd;
    logic [SAMPLE_BITS-1:0] peaks [NUM_CHANNELS];
    t_class_res             class_res;

    always_comb begin
        peak_cmd.sample_en = in_consume && (r_in_action == ACT_SAMPLE);
        peak_cmd.clear     = in_consume && (r_in_action == ACT_CLEAR);
        peak_cmd.channel   = r_in_channel;
    end

    wsp_peak_bank #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_peak_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (peak_cmd),
        .i_sample (r_in_sample),
        .o_peaks  (peaks)
    );

    wsp_classify #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_classify (
        .i_peaks           (peaks),
        .i_thr_side_a      (r_thr_side_a),
        .i_thr_side_b      (r_thr_side_b),
        .i_thr_front_left  (r_thr_front_left),
        .i_thr_front_right (r_thr_front_right),
        .i_heading         (r_in_heading),
        .o_res             (class_res)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic       r_out_valid;
    t_class_res r_out;
    logic       out_load;

    assign out_load = in_consume && in_is_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= class_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_wall_bits   = r_out.wall_bits;
    assign o_side_a_lamp = r_out.side_a;
    assign o_front_lamp  = r_out.front;
    assign o_side_b_lamp = r_out.side_b;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input is held back only for a classify item blocked by a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && in_is_class && o_valid && i_stall))
        else $error("input stalled without a blocked classify item");

    // Each lamp lit puts exactly one bit into the wall nibble
    a_nibble_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_wall_bits[7:4] == WALL_FILL[7:4]) &&
            ($countones(o_wall_bits[3:0]) ==
             ({1'b0, o_side_a_lamp} + {1'b0, o_front_lamp} + {1'b0, o_side_b_lamp})))
        else $error("wall nibble does not match the lamps");

    // A retired clear item leaves every peak at zero
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        peak_cmd.clear |=> (peaks[0] == '0) && (peaks[1] == '0) &&
            (peaks[2] == '0) && (peaks[3] == '0))
        else $error("peaks not cleared");

    // A classify item that retires always yields a result next cycle
    a_result_after_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid)
        else $error("classify item produced no result");

endmodule
